/* src/m3a_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3a_pkg
// Shared types, constants and helper functions of the 3x3 matrix unit.
// ----------------------------------------------------------------------------
package m3a_pkg;

  localparam int ELEM_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int CORDIC_N  = 16;
  localparam int ACC_W     = 2 * ELEM_W;
  localparam int ROW_W     = 3 * ELEM_W;
  localparam int ACC_ROW_W = 3 * ACC_W;
  localparam int SCALAR_W  = 16;
  localparam int ANGLE_W   = 14;
  localparam int IQ        = 30;
  localparam int TRIG_W    = 18;
  localparam int Z_W       = 34;
  localparam int IT_W      = $clog2(CORDIC_N);

  // pi in q30 as quotient and remainder over the half turn
  localparam int PI_QUO   = 1171270;
  localparam int PI_REM   = 1124;
  // divide by 45 as multiply and shift, exact below 2^15
  localparam int RECIP_45 = 46604;
  localparam int RECIP_SH = 21;

  localparam logic [31:0] GAIN_Q30 = 32'd652032874;
  localparam int HALF_TURN    = 2880;
  localparam int QUARTER_TURN = 1440;

  typedef enum logic [2:0] {
    MODE_LOAD, MODE_ADD, MODE_SUB, MODE_MUL,
    MODE_SCALE, MODE_ROTX, MODE_ROTY, MODE_ROTZ
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE, S_ROT, S_RD, S_LAT, S_MUL, S_ACC, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    CP_IDLE, CP_DIV, CP_ITER, CP_FIN
  } cphase_e;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
  } trig_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input logic [IT_W-1:0] i);
    logic [31:0] v;
    case (i)
      4'd0:    v = 32'd843314857;
      4'd1:    v = 32'd497837829;
      4'd2:    v = 32'd263043837;
      4'd3:    v = 32'd133525159;
      4'd4:    v = 32'd67021687;
      4'd5:    v = 32'd33543516;
      4'd6:    v = 32'd16775851;
      4'd7:    v = 32'd8388437;
      4'd8:    v = 32'd4194283;
      4'd9:    v = 32'd2097149;
      4'd10:   v = 32'd1048576;
      4'd11:   v = 32'd524288;
      4'd12:   v = 32'd262144;
      4'd13:   v = 32'd131072;
      4'd14:   v = 32'd65536;
      4'd15:   v = 32'd32768;
      default: v = 32'd0;
    endcase
    return $signed({{(Z_W-32){1'b0}}, v});
  endfunction

  // rotation matrix element at row k, column j
  function automatic logic signed [ELEM_W-1:0] rot_elem(
    input mode_e m, input logic [1:0] k, input logic [1:0] j,
    input logic signed [TRIG_W-1:0] c, input logic signed [TRIG_W-1:0] s);
    logic signed [ELEM_W-1:0] cx, sx, one, r;
    cx  = ELEM_W'(c);
    sx  = ELEM_W'(s);
    one = ELEM_W'(1) <<< FRAC_W;
    r   = '0;
    case (m)
      MODE_ROTX: begin
        if (k == 2'd0 && j == 2'd0) r = one;
        if (k == 2'd1 && j == 2'd1) r = cx;
        if (k == 2'd1 && j == 2'd2) r = -sx;
        if (k == 2'd2 && j == 2'd1) r = sx;
        if (k == 2'd2 && j == 2'd2) r = cx;
      end
      MODE_ROTY: begin
        if (k == 2'd0 && j == 2'd0) r = cx;
        if (k == 2'd0 && j == 2'd2) r = sx;
        if (k == 2'd1 && j == 2'd1) r = one;
        if (k == 2'd2 && j == 2'd0) r = -sx;
        if (k == 2'd2 && j == 2'd2) r = cx;
      end
      default: begin
        if (k == 2'd0 && j == 2'd0) r = cx;
        if (k == 2'd0 && j == 2'd1) r = -sx;
        if (k == 2'd1 && j == 2'd0) r = sx;
        if (k == 2'd1 && j == 2'd1) r = cx;
        if (k == 2'd2 && j == 2'd2) r = one;
      end
    endcase
    return r;
  endfunction

  // saturate to an element, msb of the result is the overflow flag
  function automatic logic [ELEM_W:0] sat_elem(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] emax, emin;
    logic [ELEM_W:0] r;
    emax = $signed({{(ACC_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}});
    emin = ~emax;
    if (v > emax) r = {1'b1, emax[ELEM_W-1:0]};
    else if (v < emin) r = {1'b1, emin[ELEM_W-1:0]};
    else r = {1'b0, v[ELEM_W-1:0]};
    return r;
  endfunction

endpackage

/* src/m3a_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3a_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
module m3a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/m3a_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3a_cordic
// Angle fold, degree-to-radian scaling by reciprocal multiply and iterative
// cordic for cos and sin in fixed point.
// ----------------------------------------------------------------------------
module m3a_cordic (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [m3a_pkg::ANGLE_W-1:0]   angle_i,
  output m3a_pkg::trig_t                       trig_o
);
  import m3a_pkg::*;

  cphase_e phase_q, phase_d;
  logic ld_num, div_en, it_en, fin_en;

  logic signed [15:0] a16, r1, r2, r3;
  logic               fold, neg;
  logic [10:0]        mag;

  logic [20:0]        tpart_q;
  logic [30:0]        qhi_q, tmul, quo;
  logic [IT_W-1:0]    it_q;
  logic               flip_q, neg_q, done_q;
  logic signed [Z_W-1:0] x_q, y_q, z_q, dx, dy, xr, yr, xs, ys;
  logic signed [TRIG_W-1:0] c_q, s_q, cr, sr;

  always_comb begin
    a16 = 16'(angle_i);
    if (a16 >= 16'sd5760) r1 = a16 - 16'sd5760;
    else if (a16 <= -16'sd5760) r1 = a16 + 16'sd5760;
    else r1 = a16;
    if (r1 >= 16'(HALF_TURN)) r2 = r1 - 16'sd5760;
    else if (r1 < -16'(HALF_TURN)) r2 = r1 + 16'sd5760;
    else r2 = r1;
    fold = 1'b0;
    r3   = r2;
    if (r2 > 16'(QUARTER_TURN)) begin
      r3   = r2 - 16'(HALF_TURN);
      fold = 1'b1;
    end else if (r2 < -16'(QUARTER_TURN)) begin
      r3   = r2 + 16'(HALF_TURN);
      fold = 1'b1;
    end
    neg = r3[15];
    mag = neg ? 11'(-r3) : 11'(r3);
  end

  // remainder part over the half turn: drop 64, then divide by 45
  assign tmul    = 31'(tpart_q[20:6]) * 31'(RECIP_45);
  assign quo     = qhi_q + (tmul >> RECIP_SH);
  assign dx      = y_q >>> it_q;
  assign dy      = x_q >>> it_q;
  assign xr      = x_q + (Z_W'(1) <<< (IQ - FRAC_W - 1));
  assign yr      = y_q + (Z_W'(1) <<< (IQ - FRAC_W - 1));
  assign xs      = xr >>> (IQ - FRAC_W);
  assign ys      = yr >>> (IQ - FRAC_W);
  assign cr      = flip_q ? -xs[TRIG_W-1:0] : xs[TRIG_W-1:0];
  assign sr      = flip_q ? -ys[TRIG_W-1:0] : ys[TRIG_W-1:0];

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      CP_IDLE: if (start_i) phase_d = CP_DIV;
      CP_DIV:  phase_d = CP_ITER;
      CP_ITER: if (it_q == IT_W'(CORDIC_N - 1)) phase_d = CP_FIN;
      CP_FIN:  phase_d = CP_IDLE;
      default: phase_d = CP_IDLE;
    endcase
  end

  // phase strobes
  always_comb begin
    ld_num = 1'b0;
    div_en = 1'b0;
    it_en  = 1'b0;
    fin_en = 1'b0;
    case (phase_q)
      CP_IDLE: ld_num = start_i;
      CP_DIV:  div_en = 1'b1;
      CP_ITER: it_en  = 1'b1;
      CP_FIN:  fin_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= CP_IDLE;
      done_q  <= 1'b0;
      it_q    <= '0;
    end else begin
      phase_q <= phase_d;
      done_q  <= fin_en;
      if (div_en) it_q <= '0;
      else if (it_en) it_q <= it_q + IT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_num) begin
      tpart_q <= 21'(mag) * 21'(PI_REM) + 21'(QUARTER_TURN);
      qhi_q   <= 31'(mag) * 31'(PI_QUO);
      flip_q  <= fold;
      neg_q   <= neg;
    end
    if (div_en) begin
      x_q <= $signed({{(Z_W-32){1'b0}}, GAIN_Q30});
      y_q <= '0;
      z_q <= neg_q ? -$signed({{(Z_W-31){1'b0}}, quo})
                   :  $signed({{(Z_W-31){1'b0}}, quo});
    end
    if (it_en) begin
      if (!z_q[Z_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_q30(it_q);
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_q30(it_q);
      end
    end
    if (fin_en) begin
      c_q <= cr;
      s_q <= sr;
    end
  end

  assign trig_o.done = done_q;
  assign trig_o.c    = c_q;
  assign trig_o.s    = s_q;

endmodule

/* src/matrix3_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_alu
// 3x3 Q16.16 matrix unit: held matrix load, add, sub, multiply, scale, rotate.
// ----------------------------------------------------------------------------
// One word is handled at a time. Load writes its row from idle; add and sub
// take one row pass plus output; a multiply row takes 3 row passes, paced
// by the single 32x32 multiplier; scale takes one pass per row; rotate
// runs angle scaling and cordic before 3 row passes. Held matrix and
// accumulator live in two 3-row rams read one row per pass; both read as
// zero after reset.
module matrix3_alu (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          mode_i,
  input  logic [1:0]                          row_i,
  input  logic signed [m3a_pkg::ELEM_W-1:0]   elem0_i,
  input  logic signed [m3a_pkg::ELEM_W-1:0]   elem1_i,
  input  logic signed [m3a_pkg::ELEM_W-1:0]   elem2_i,
  input  logic signed [m3a_pkg::SCALAR_W-1:0] scalar_i,
  input  logic signed [m3a_pkg::ANGLE_W-1:0]  angle_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          out_row_o,
  output logic signed [m3a_pkg::ELEM_W-1:0]   res0_o,
  output logic signed [m3a_pkg::ELEM_W-1:0]   res1_o,
  output logic signed [m3a_pkg::ELEM_W-1:0]   res2_o,
  output logic                                overflow_o,
  output logic                                last_o
);
  import m3a_pkg::*;

  state_e state_q, state_d;
  mode_e  mode_q, mode_in;
  logic   accept, addsub, is_rot, emit, out_free, fire, last_prod;
  logic   a_we, acc_we, out_load, cord_start;

  logic [1:0] row_q, i_q, j_q, k_q, cur_addr, a_idx;
  logic signed [ELEM_W-1:0]   e_q [3];
  logic signed [SCALAR_W-1:0] scalar_q;
  logic signed [ELEM_W-1:0]   a_row_q [3];
  logic signed [ACC_W-1:0]    res_q [3];
  logic signed [2*ELEM_W-1:0] prod_q;
  logic signed [ELEM_W-1:0]   a_op, b_op;
  logic signed [ACC_W-1:0]    term;
  logic signed [ACC_W-1:0]    fin [3];
  logic [ELEM_W:0]            sat [3];
  logic [2:0] a_vld_q, acc_vld_q;
  logic [ROW_W-1:0]     a_rdata;
  logic [ACC_ROW_W-1:0] acc_rdata;
  logic                 out_valid_q;
  trig_t                trig;

  assign mode_in  = mode_e'(mode_i);
  assign accept   = in_valid_i && !in_stall_o;
  assign addsub   = (mode_q == MODE_ADD) || (mode_q == MODE_SUB);
  assign is_rot   = (mode_q == MODE_ROTX) || (mode_q == MODE_ROTY) || (mode_q == MODE_ROTZ);
  assign emit     = (mode_q != MODE_MUL) || (row_q == 2'd2);
  assign out_free = !out_valid_q || !out_stall_i;
  assign fire     = !emit || out_free;
  assign last_prod = (j_q == 2'd2) && (!is_rot || k_q == 2'd2);
  assign cur_addr = addsub ? row_q : i_q;

  m3a_ram #(.WIDTH(ROW_W), .DEPTH(3)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (row_i),
    .wdata_i ({elem2_i, elem1_i, elem0_i}),
    .raddr_i (cur_addr),
    .rdata_o (a_rdata)
  );

  m3a_ram #(.WIDTH(ACC_ROW_W), .DEPTH(3)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (i_q),
    .wdata_i ({res_q[2], res_q[1], res_q[0]}),
    .raddr_i (cur_addr),
    .rdata_o (acc_rdata)
  );

  m3a_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .angle_i (angle_i),
    .trig_o  (trig)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mode_in)
            MODE_LOAD:  state_d = S_IDLE;
            MODE_ADD, MODE_SUB, MODE_MUL:
                        state_d = (row_i == 2'd3) ? S_IDLE : S_RD;
            MODE_SCALE: state_d = S_RD;
            default:    state_d = S_ROT;
          endcase
        end
      end
      S_ROT:   if (trig.done) state_d = S_RD;
      S_RD:    state_d = S_LAT;
      S_LAT:   state_d = addsub ? S_OUT : S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC:   state_d = last_prod ? S_OUT : S_MUL;
      S_OUT: begin
        if (fire) state_d = (addsub || i_q == 2'd2) ? S_IDLE : S_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // strobes
  always_comb begin
    in_stall_o = 1'b1;
    a_we       = 1'b0;
    acc_we     = 1'b0;
    out_load   = 1'b0;
    cord_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        a_we       = accept && (mode_in == MODE_LOAD) && (row_i != 2'd3);
        cord_start = accept && (mode_in == MODE_ROTX || mode_in == MODE_ROTY ||
                                mode_in == MODE_ROTZ);
      end
      S_OUT: begin
        acc_we   = fire && (mode_q == MODE_MUL);
        out_load = fire && emit;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (mode_q)
      MODE_MUL:   a_idx = row_q;
      MODE_SCALE: a_idx = j_q;
      default:    a_idx = k_q;
    endcase
    a_op = a_row_q[a_idx];
    case (mode_q)
      MODE_MUL:   b_op = e_q[j_q];
      MODE_SCALE: b_op = ELEM_W'(scalar_q);
      default:    b_op = rot_elem(mode_q, k_q, j_q, trig.c, trig.s);
    endcase
    term = (mode_q == MODE_SCALE) ? prod_q : (prod_q >>> FRAC_W);
    for (int n = 0; n < 3; n++) begin
      if (mode_q == MODE_ADD) fin[n] = ACC_W'(a_row_q[n]) + ACC_W'(e_q[n]);
      else if (mode_q == MODE_SUB) fin[n] = ACC_W'(a_row_q[n]) - ACC_W'(e_q[n]);
      else fin[n] = res_q[n];
      sat[n] = sat_elem(fin[n]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      a_vld_q     <= '0;
      acc_vld_q   <= '0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (a_we) a_vld_q[row_i] <= 1'b1;
      if (acc_we) acc_vld_q[i_q] <= 1'b1;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (accept) i_q <= '0;
      else if (state_q == S_OUT && fire) i_q <= i_q + 2'd1;
      if (state_q == S_LAT) begin
        j_q <= '0;
        k_q <= '0;
      end else if (state_q == S_ACC) begin
        if (is_rot && k_q != 2'd2) k_q <= k_q + 2'd1;
        else begin
          k_q <= '0;
          j_q <= j_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_in;
      row_q    <= row_i;
      e_q[0]   <= elem0_i;
      e_q[1]   <= elem1_i;
      e_q[2]   <= elem2_i;
      scalar_q <= scalar_i;
    end
    if (state_q == S_LAT) begin
      for (int n = 0; n < 3; n++) begin
        a_row_q[n] <= a_vld_q[cur_addr] ? a_rdata[n*ELEM_W +: ELEM_W] : '0;
        res_q[n]   <= (mode_q == MODE_MUL && row_q != 2'd0 && acc_vld_q[cur_addr]) ?
                      acc_rdata[n*ACC_W +: ACC_W] : '0;
      end
    end
    if (state_q == S_MUL) prod_q <= a_op * b_op;
    if (state_q == S_ACC) res_q[j_q] <= res_q[j_q] + term;
    if (out_load) begin
      out_row_o  <= cur_addr;
      res0_o     <= sat[0][ELEM_W-1:0];
      res1_o     <= sat[1][ELEM_W-1:0];
      res2_o     <= sat[2][ELEM_W-1:0];
      overflow_o <= sat[0][ELEM_W] | sat[1][ELEM_W] | sat[2][ELEM_W];
      last_o     <= (cur_addr == 2'd2);
    end
  end

  assign out_valid_o = out_valid_q;

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i)) else $error("output overwritten");
  a_acc_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_we |-> (mode_q == MODE_MUL)) else $error("accumulator written outside multiply");
  a_trig_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig.done |-> (state_q == S_ROT)) else $error("cordic done while not waiting");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_we |=> (state_q == S_IDLE)) else $error("load left idle");

endmodule

/* test/matrix3_alu_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_alu_tb
// Self-checking bench for the 3x3 fixed-point matrix unit: directed words for
// load, add, sub, multiply, scale and the three rotations, then random
// matrix sequences with random gaps and output stalls, checked row by row
// against an in-bench predictor.
// ----------------------------------------------------------------------------
module matrix3_alu_tb;
  import m3a_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam longint EMAX = 64'sd2147483647;
  localparam longint EMIN = -64'sd2147483648;

  typedef struct {
    logic [1:0]  row;
    logic [31:0] r0, r1, r2;
    logic        ovf;
    logic        last;
  } row_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] mode = '0;
  logic [1:0] row = '0;
  logic signed [31:0] elem0 = '0, elem1 = '0, elem2 = '0;
  logic signed [15:0] scalar = '0;
  logic signed [13:0] angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_row;
  logic signed [31:0] res0, res1, res2;
  logic overflow, last;

  row_result_t result_q[$];
  longint held[9];
  longint acc[9];
  longint atan_tab[CORDIC_N];
  longint gain;
  int errors = 0;
  int idle_cycles = 0;
  bit hold_req = 0;
  int hold_left = 0;

  always #1 clk_i = ~clk_i;

  matrix3_alu u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mode_i(mode), .row_i(row),
    .elem0_i(elem0), .elem1_i(elem1), .elem2_i(elem2),
    .scalar_i(scalar), .angle_i(angle),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_row_o(out_row), .res0_o(res0), .res1_o(res1), .res2_o(res2),
    .overflow_o(overflow), .last_o(last)
  );

  function automatic longint unsigned atan_inv_q60(longint unsigned n);
    longint unsigned pw, nn, sum, k, t;
    pw = (64'd1 << 60) / n;
    nn = n * n;
    sum = 0;
    k = 0;
    while (pw != 0) begin
      t = pw / (2 * k + 1);
      if (k[0]) sum -= t;
      else sum += t;
      pw /= nn;
      k++;
    end
    return sum;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic build_trig_tables();
    longint unsigned v, a;
    v = 64'd1 << 60;
    for (int i = 0; i < CORDIC_N; i++) begin
      a = (i == 0) ? atan_inv_q60(2) + atan_inv_q60(3) : atan_inv_q60(64'd1 << i);
      atan_tab[i] = longint'((a + (64'd1 << 29)) >> 30);
      v -= v / ((64'd1 << (2 * i)) + 1);
    end
    gain = longint'(int_sqrt(v));
  endtask

  task automatic cordic_sin_cos(input longint ang, output longint c, output longint s);
    longint r, x, y, z, dx, dy, rad;
    longint unsigned m, pi_q30;
    bit flip, neg;
    pi_q30 = (64'd3141592 << 30) / 64'd1000000;
    flip = 0;
    r = ang % (2 * HALF_TURN);
    if (r >= HALF_TURN) r -= 2 * HALF_TURN;
    if (r < -HALF_TURN) r += 2 * HALF_TURN;
    if (r > QUARTER_TURN) begin r -= HALF_TURN; flip = 1; end
    if (r < -QUARTER_TURN) begin r += HALF_TURN; flip = 1; end
    neg = r < 0;
    m = neg ? -r : r;
    m = (m * pi_q30 + HALF_TURN / 2) / HALF_TURN;
    rad = neg ? -longint'(m) : longint'(m);
    x = gain;
    y = 0;
    z = rad;
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin x -= dx; y += dy; z -= atan_tab[i]; end
      else begin x += dx; y -= dy; z += atan_tab[i]; end
    end
    x = (x + (64'sd1 << 13)) >>> 14;
    y = (y + (64'sd1 << 13)) >>> 14;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint clamp(longint v, inout logic ovf);
    if (v > EMAX) begin ovf = 1; return EMAX; end
    if (v < EMIN) begin ovf = 1; return EMIN; end
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FRAC_W;
  endfunction

  task automatic push_row(int i, longint v0, longint v1, longint v2, logic ovf);
    row_result_t r;
    r.row = i[1:0];
    r.ovf = 0;
    r.r0 = 32'(clamp(v0, r.ovf));
    r.r1 = 32'(clamp(v1, r.ovf));
    r.r2 = 32'(clamp(v2, r.ovf));
    r.ovf |= ovf;
    r.last = (i == 2);
    result_q.push_back(r);
  endtask

  task automatic predict_word(mode_e md, logic [1:0] rw, longint e[3],
                              longint sc, longint ang);
    longint rot[9], c, s, v[3];
    int k;
    k = rw;
    case (md)
      MODE_LOAD: if (rw != 3) for (int j = 0; j < 3; j++) held[k*3+j] = e[j];
      MODE_ADD, MODE_SUB: if (rw != 3) begin
        for (int j = 0; j < 3; j++)
          v[j] = (md == MODE_ADD) ? held[k*3+j] + e[j] : held[k*3+j] - e[j];
        push_row(k, v[0], v[1], v[2], 0);
      end
      MODE_MUL: if (rw != 3) begin
        if (rw == 0) for (int i = 0; i < 9; i++) acc[i] = 0;
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) acc[i*3+j] += qmul(held[i*3+k], e[j]);
        if (rw == 2)
          for (int i = 0; i < 3; i++) push_row(i, acc[i*3], acc[i*3+1], acc[i*3+2], 0);
      end
      MODE_SCALE:
        for (int i = 0; i < 3; i++)
          push_row(i, held[i*3] * sc, held[i*3+1] * sc, held[i*3+2] * sc, 0);
      default: begin
        cordic_sin_cos(ang, c, s);
        for (int i = 0; i < 9; i++) rot[i] = 0;
        if (md == MODE_ROTX) begin
          rot[0] = 65536; rot[4] = c; rot[5] = -s; rot[7] = s; rot[8] = c;
        end else if (md == MODE_ROTY) begin
          rot[0] = c; rot[2] = s; rot[4] = 65536; rot[6] = -s; rot[8] = c;
        end else begin
          rot[0] = c; rot[1] = -s; rot[3] = s; rot[4] = c; rot[8] = 65536;
        end
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            v[j] = 0;
            for (int n = 0; n < 3; n++) v[j] += qmul(held[i*3+n], rot[n*3+j]);
          end
          push_row(i, v[0], v[1], v[2], 0);
        end
      end
    endcase
  endtask

  function automatic logic signed [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return (($urandom_range(0, 1) == 1) ? 32'h7fffffff : 32'h80000000);
      2: return $signed(32'(int'($urandom_range(0, 512)) - 256)) <<< 16;
      default: return $signed(32'(int'($urandom_range(0, 1 << 20)) - (1 << 19)));
    endcase
  endfunction

  task automatic send_word(mode_e md, logic [1:0] rw, logic signed [31:0] e0,
                           logic signed [31:0] e1, logic signed [31:0] e2,
                           logic signed [15:0] sc, logic signed [13:0] ang);
    longint e[3];
    int gap;
    mode <= md;
    row <= rw;
    elem0 <= e0;
    elem1 <= e1;
    elem2 <= e2;
    scalar <= sc;
    angle <= ang;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    e[0] = e0;
    e[1] = e1;
    e[2] = e2;
    predict_word(md, rw, e, sc, ang);
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_matrix(logic signed [31:0] m[9]);
    for (int i = 0; i < 3; i++)
      send_word(MODE_LOAD, i[1:0], m[i*3], m[i*3+1], m[i*3+2], 0, 0);
  endtask

  task automatic load_random();
    logic signed [31:0] m[9];
    for (int i = 0; i < 9; i++) m[i] = rand_elem();
    load_matrix(m);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // receiver side: random short/long stalls, plus a long requested hold
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 30) begin
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 2) begin
      hold_left = $urandom_range(10, 40);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    row_result_t x;
    if (rst_ni && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected row %0d res %h %h %h", $time, out_row, res0, res1, res2);
        errors++;
      end else begin
        x = result_q.pop_front();
        if (out_row !== x.row || res0 !== x.r0 || res1 !== x.r1 || res2 !== x.r2 ||
            overflow !== x.ovf || last !== x.last) begin
          $display("%0t: mismatch exp row %0d %h %h %h ovf %b last %b", $time,
                   x.row, x.r0, x.r1, x.r2, x.ovf, x.last);
          $display("%0t:          got row %0d %h %h %h ovf %b last %b", $time,
                   out_row, res0, res1, res2, overflow, last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("matrix3_alu_tb: done, errors");
      $finish;
    end
  end

  task automatic test_add_sub_extremes();
    logic signed [31:0] m[9] = '{32'h7fffffff, 32'h80000000, 32'h00010000,
                                 32'h80000000, 32'h7fffffff, 32'hffff0000,
                                 32'h00000000, 32'hffffffff, 32'h00000001};
    load_matrix(m);
    send_word(MODE_ADD, 0, 32'h7fffffff, 32'h80000000, 32'h00000000, 0, 0);
    send_word(MODE_SUB, 1, 32'h7fffffff, 32'h80000000, 32'h00010000, 0, 0);
    send_word(MODE_ADD, 2, 32'h00000001, 32'hffffffff, 32'h7fffffff, 0, 0);
    send_word(MODE_SUB, 2, 32'h80000000, 32'h00000001, 32'hffffffff, 0, 0);
    wait_drained();
  endtask

  task automatic test_multiply();
    send_word(MODE_MUL, 0, 32'h7fffffff, 32'h80000000, 32'h00020000, 0, 0);
    send_word(MODE_MUL, 1, 32'h80000000, 32'h7fffffff, 32'hfffe8000, 0, 0);
    send_word(MODE_MUL, 2, 32'h00010000, 32'h00000001, 32'hffffffff, 0, 0);
    // rows out of order just keep summing
    send_word(MODE_MUL, 1, 32'h00030000, 32'h00010000, 32'h00008000, 0, 0);
    send_word(MODE_MUL, 2, 32'h00010000, 32'hffff0000, 32'h00000000, 0, 0);
    wait_drained();
  endtask

  task automatic test_scale();
    send_word(MODE_SCALE, 3, 0, 0, 0, 16'sh8000, 0);
    send_word(MODE_SCALE, 0, 0, 0, 0, 16'sh7fff, 0);
    send_word(MODE_SCALE, 1, 0, 0, 0, 16'sd0, 0);
    send_word(MODE_SCALE, 2, 0, 0, 0, -16'sd1, 0);
    wait_drained();
  endtask

  task automatic test_rotate();
    logic signed [31:0] m[9] = '{32'h00010000, 32'h00020000, 32'hfffd0000,
                                 32'h00008000, 32'h7fffffff, 32'h80000000,
                                 32'h00001234, 32'hffff0000, 32'h00050000};
    load_matrix(m);
    send_word(MODE_ROTX, 0, 0, 0, 0, 0, 14'sd0);
    send_word(MODE_ROTY, 3, 0, 0, 0, 0, 14'sd1440);
    send_word(MODE_ROTZ, 1, 0, 0, 0, 0, -14'sd1440);
    send_word(MODE_ROTX, 2, 0, 0, 0, 0, 14'sd2880);
    send_word(MODE_ROTY, 0, 0, 0, 0, 0, 14'sd5760);
    send_word(MODE_ROTZ, 0, 0, 0, 0, 0, -14'sd5760);
    send_word(MODE_ROTZ, 0, 0, 0, 0, 0, 14'sd4321);
    wait_drained();
  endtask

  task automatic test_row_three_ignored();
    send_word(MODE_LOAD, 3, 32'h12345678, 32'h12345678, 32'h12345678, 0, 0);
    send_word(MODE_ADD, 3, 0, 0, 0, 0, 0);
    send_word(MODE_SUB, 3, 0, 0, 0, 0, 0);
    send_word(MODE_MUL, 3, 32'h00010000, 0, 0, 0, 0);
    send_word(MODE_SCALE, 0, 0, 0, 0, 16'sd1, 0);
    wait_drained();
  endtask

  task automatic random_word();
    mode_e md;
    logic [1:0] rw;
    md = mode_e'($urandom_range(0, 7));
    rw = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    send_word(md, rw, rand_elem(), rand_elem(), rand_elem(), 16'($urandom()),
              14'($signed(int'($urandom_range(0, 11520)) - 5760)));
  endtask

  task automatic test_backpressure();
    load_random();
    hold_req = 1;
    for (int i = 0; i < 3; i++)
      send_word(MODE_ROTZ, 0, 0, 0, 0, 0, 14'($urandom_range(0, 5760)));
    for (int i = 0; i < 3; i++)
      send_word(MODE_MUL, i[1:0], rand_elem(), rand_elem(), rand_elem(), 0, 0);
    send_word(MODE_SCALE, 0, 0, 0, 0, 16'($urandom()), 0);
    wait_drained();
  endtask

  task automatic test_random_sequences();
    int sent;
    sent = 0;
    while (sent < 140) begin
      case ($urandom_range(0, 9))
        0, 1: begin load_random(); sent += 3; end
        2, 3: begin
          for (int i = 0; i < 3; i++)
            send_word(MODE_MUL, i[1:0], rand_elem(), rand_elem(), rand_elem(), 0, 0);
          sent += 3;
        end
        4: begin
          for (int i = 0; i < 3; i++)
            send_word($urandom_range(0, 1) ? MODE_ADD : MODE_SUB, i[1:0],
                      rand_elem(), rand_elem(), rand_elem(), 0, 0);
          sent += 3;
        end
        5: begin
          send_word(mode_e'($urandom_range(MODE_ROTX, MODE_ROTZ)), 0, 0, 0, 0, 0,
                    14'($signed(int'($urandom_range(0, 11520)) - 5760)));
          sent++;
        end
        6: begin
          send_word(MODE_SCALE, 2'($urandom()), 0, 0, 0, 16'($urandom()), 0);
          sent++;
        end
        default: begin random_word(); sent++; end
      endcase
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    build_trig_tables();
    for (int i = 0; i < 9; i++) begin held[i] = 0; acc[i] = 0; end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_add_sub_extremes();
    test_multiply();
    test_scale();
    test_rotate();
    test_row_three_ignored();
    test_backpressure();
    test_random_sequences();
    if (errors == 0) $display("matrix3_alu_tb: done, clean");
    else $display("matrix3_alu_tb: done, errors");
    $finish;
  end

endmodule
